/* sv/blake2b_work_nonce_check_assert.svh */
// Assertion macros for the BLAKE2b nonce checker.
// Included by the top level; no other dependencies.
`ifndef BLAKE2B_WORK_NONCE_CHECK_ASSERT_SVH
`define BLAKE2B_WORK_NONCE_CHECK_ASSERT_SVH
`ifndef SYNTH
`define B2W_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");
`define B2W_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");
`else
`define B2W_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define B2W_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/b2wnc_pkg.sv */
// Shared constants, types and mix helpers for the BLAKE2b nonce checker.
// No dependencies.
package b2wnc_pkg;

  localparam int unsigned NumRounds  = 12;
  localparam int unsigned NumHalves  = 2 * NumRounds;
  localparam int unsigned NumCfgRegs = 5;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned MsgBytes   = 40;
  localparam int unsigned DigBytes   = 8;

  typedef logic [63:0] word_t;
  typedef word_t state_t [16];
  typedef word_t msg_t [16];

  localparam logic [CfgIdxW-1:0] CFG_HASH0  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HASH1  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_HASH2  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_HASH3  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_THRESH = 3'd4;

  localparam word_t IV0 = 64'h6a09e667f3bcc908;
  localparam word_t IV1 = 64'hbb67ae8584caa73b;
  localparam word_t IV2 = 64'h3c6ef372fe94f82b;
  localparam word_t IV3 = 64'ha54ff53a5f1d36f1;
  localparam word_t IV4 = 64'h510e527fade682d1;
  localparam word_t IV5 = 64'h9b05688c2b3e6c1f;
  localparam word_t IV6 = 64'h1f83d9abfb41bd6b;
  localparam word_t IV7 = 64'h5be0cd19137e2179;

  // Parameter block word: digest length 8, fanout 1, depth 1.
  localparam word_t H0 = IV0 ^ 64'h0000_0000_0101_0000 ^ 64'(DigBytes);

  // Sigma table, one 64-bit row per round mod 10, nibble k = index k.
  function automatic logic [3:0] sigma(input logic [3:0] row, input logic [3:0] k);
    logic [63:0] r;
    unique case (row)
      4'd0: r = 64'hfedcba9876543210;
      4'd1: r = 64'h357b20c16df984ae;
      4'd2: r = 64'h491763eadf250c8b;
      4'd3: r = 64'h8f04a562ebcd1397;
      4'd4: r = 64'hd386cb1efa427509;
      4'd5: r = 64'h91ef57d438b0a6c2;
      4'd6: r = 64'hb8293670a4def15c;
      4'd7: r = 64'ha2684f05931ce7bd;
      4'd8: r = 64'h5a417d2c803b9ef6;
      4'd9: r = 64'h0dc3e9bf5167482a;
      default: r = '0;
    endcase
    return r[k*4 +: 4];
  endfunction

  // Full quarter mix of one column or diagonal.
  function automatic state_t mix(input state_t v, input int unsigned a, input int unsigned b,
                                 input int unsigned c, input int unsigned d,
                                 input word_t x, input word_t y);
    state_t w;
    word_t t;
    w = v;
    w[a] = w[a] + w[b] + x;
    t = w[d] ^ w[a];      w[d] = {t[31:0], t[63:32]};
    w[c] = w[c] + w[d];
    t = w[b] ^ w[c];      w[b] = {t[23:0], t[63:24]};
    w[a] = w[a] + w[b] + y;
    t = w[d] ^ w[a];      w[d] = {t[15:0], t[63:16]};
    w[c] = w[c] + w[d];
    t = w[b] ^ w[c];      w[b] = {t[62:0], t[63]};
    return w;
  endfunction

endpackage

/* sv/b2wnc_half_round.sv */
// One pipeline stage: the column or diagonal half of a BLAKE2b round.
// Depends on b2wnc_pkg.
module b2wnc_half_round #(
  parameter int unsigned RoundIdx = 0,
  parameter bit          Diag     = 1'b0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              vld_in,
  input  b2wnc_pkg::word_t  nonce_in,
  input  b2wnc_pkg::state_t v_in,
  input  b2wnc_pkg::msg_t   m,
  output logic              vld_out,
  output b2wnc_pkg::word_t  nonce_out,
  output b2wnc_pkg::state_t v_out
);
  import b2wnc_pkg::*;

  localparam logic [3:0] Row  = 4'(RoundIdx % 10);
  localparam logic [3:0] Base = Diag ? 4'd8 : 4'd0;

  state_t v_nxt;
  state_t v_r;
  word_t  nonce_r;
  logic   vld_r;

  // Four independent mixes on disjoint words
  always_comb begin
    if (!Diag) begin
      v_nxt = mix(v_in, 0, 4, 8, 12, m[sigma(Row, Base)], m[sigma(Row, Base + 4'd1)]);
      v_nxt = mix(v_nxt, 1, 5, 9, 13, m[sigma(Row, Base + 4'd2)], m[sigma(Row, Base + 4'd3)]);
      v_nxt = mix(v_nxt, 2, 6, 10, 14, m[sigma(Row, Base + 4'd4)], m[sigma(Row, Base + 4'd5)]);
      v_nxt = mix(v_nxt, 3, 7, 11, 15, m[sigma(Row, Base + 4'd6)], m[sigma(Row, Base + 4'd7)]);
    end else begin
      v_nxt = mix(v_in, 0, 5, 10, 15, m[sigma(Row, Base)], m[sigma(Row, Base + 4'd1)]);
      v_nxt = mix(v_nxt, 1, 6, 11, 12, m[sigma(Row, Base + 4'd2)], m[sigma(Row, Base + 4'd3)]);
      v_nxt = mix(v_nxt, 2, 7, 8, 13, m[sigma(Row, Base + 4'd4)], m[sigma(Row, Base + 4'd5)]);
      v_nxt = mix(v_nxt, 3, 4, 9, 14, m[sigma(Row, Base + 4'd6)], m[sigma(Row, Base + 4'd7)]);
    end
  end

  // Advance the stage when the pipe moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v_r     <= v_nxt;
      nonce_r <= nonce_in;
    end
  end

  assign vld_out   = vld_r;
  assign nonce_out = nonce_r;
  assign v_out     = v_r;
endmodule

/* sv/blake2b_work_nonce_check.sv */
// Top level of the BLAKE2b-64 proof-of-work nonce checker.
// Depends on b2wnc_pkg, b2wnc_half_round and the assertion header.
//
//  channel  | ports                  | word
//  ---------+------------------------+-------------------------------------------
//  in       | in_tvalid/tready/tdata | candidate_nonce[63:0]
//  out      | out_tvalid/tready/tdata| tested_nonce, digest_value, meets_threshold
//  cfg      | cfg_we/idx/data        | register index 0..4, 64-bit value
//
// The pipeline has 24 half-round stages plus an entry and an output stage.
// One nonce is accepted every cycle while out is not stalled; the 24-stage round pipeline sets that rate.
// Reset clears all valid bits and the config registers.
// A stall at out holds the whole pipe in place; nothing is lost or repeated.
`include "blake2b_work_nonce_check_assert.svh"
module blake2b_work_nonce_check (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // [63:0] candidate_nonce
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // [63:0] tested_nonce, [127:64] digest_value,
                                   // [128] meets_threshold, [135:129] zero
  input  logic         cfg_we,
  input  logic [2:0]   cfg_idx,
  input  logic [63:0]  cfg_data
);
  import b2wnc_pkg::*;

  word_t hash_r [4];
  word_t thresh_r;
  msg_t  m;
  logic  adv;

  // Config writes; indexes beyond the list fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) hash_r[i] <= '0;
      thresh_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_HASH0:  hash_r[0] <= cfg_data;
        CFG_HASH1:  hash_r[1] <= cfg_data;
        CFG_HASH2:  hash_r[2] <= cfg_data;
        CFG_HASH3:  hash_r[3] <= cfg_data;
        CFG_THRESH: thresh_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Message block; slot 0 is the nonce and differs per stage
  always_comb begin
    for (int i = 0; i < 16; i++) m[i] = '0;
    m[1] = hash_r[0];
    m[2] = hash_r[1];
    m[3] = hash_r[2];
    m[4] = hash_r[3];
  end

  // Whole pipe moves unless the output is held
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Entry stage: latch the nonce, build the initial state
  logic   vld0_r;
  word_t  nonce0_r;
  state_t v0;
  always_ff @(posedge clk) begin
    if (!rst_n) vld0_r <= 1'b0;
    else if (adv) vld0_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (adv) nonce0_r <= in_tdata;
  end

  always_comb begin
    v0[0] = H0;  v0[1] = IV1; v0[2] = IV2; v0[3] = IV3;
    v0[4] = IV4; v0[5] = IV5; v0[6] = IV6; v0[7] = IV7;
    v0[8] = IV0; v0[9] = IV1; v0[10] = IV2; v0[11] = IV3;
    v0[12] = IV4 ^ 64'(MsgBytes); v0[13] = IV5; v0[14] = ~IV6; v0[15] = IV7;
  end

  logic   vld_s   [NumHalves+1];
  word_t  nonce_s [NumHalves+1];
  state_t v_s     [NumHalves+1];
  msg_t   m_s     [NumHalves];

  assign vld_s[0]   = vld0_r;
  assign nonce_s[0] = nonce0_r;
  assign v_s[0]     = v0;

  for (genvar g = 0; g < NumHalves; g++) begin : g_half
    always_comb begin
      m_s[g]    = m;
      m_s[g][0] = nonce_s[g];
    end
    b2wnc_half_round #(.RoundIdx(g / 2), .Diag(g % 2 == 1)) u_half (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .vld_in   (vld_s[g]),
      .nonce_in (nonce_s[g]),
      .v_in     (v_s[g]),
      .m        (m_s[g]),
      .vld_out  (vld_s[g+1]),
      .nonce_out(nonce_s[g+1]),
      .v_out    (v_s[g+1])
    );
  end

  // Output stage: fold the digest and compare
  logic  out_vld_r;
  word_t dig_nxt, dig_r, onon_r;
  logic  pass_r;
  assign dig_nxt = H0 ^ v_s[NumHalves][0] ^ v_s[NumHalves][8];

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (adv) out_vld_r <= vld_s[NumHalves];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dig_r  <= dig_nxt;
      onon_r <= nonce_s[NumHalves];
      pass_r <= (dig_nxt >= thresh_r);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, pass_r, dig_r, onon_r};

  `B2W_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata))
  `B2W_ASSERT_IMPL(a_ready_tracks_out, clk, rst_n, out_tvalid && !out_tready, !in_tready)
  `B2W_ASSERT_NEXT(a_entry_valid, clk, rst_n, in_tvalid && in_tready, vld0_r)
endmodule
